// File: src/mae_pkg.sv
// Package for the movement alarm escalation block.
// Holds codes, timer constants and shared types; no dependencies.
package mae_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_MOVE_ON = 3'd1,
    OP_MOVE_OFF = 3'd2,
    OP_ARM     = 3'd3,
    OP_DISARM  = 3'd4,
    OP_CODE    = 3'd5
  } mae_op_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_LOAD,
    SEQ_DIV,
    SEQ_OUT
  } mae_seq_e;

  localparam logic [1:0] CFG_CODE_VALUE  = 2'd0;
  localparam logic [1:0] CFG_CODE_LENGTH = 2'd1;
  localparam logic [1:0] CFG_SEVERITY    = 2'd2;

  localparam logic [1:0] CR_NONE  = 2'd0;
  localparam logic [1:0] CR_MATCH = 2'd1;
  localparam logic [1:0] CR_WRONG = 2'd2;

  localparam logic [1:0] TICKS_RISE         = 2'd2;
  localparam logic [6:0] TICKS_DECAY        = 7'd20;
  localparam logic [6:0] TICKS_DECAY_ACTIVE = 7'd120;
  localparam logic [4:0] TICKS_UNSNOOZE     = 5'd30;
  localparam logic [2:0] MAX_RETRIES        = 3'd4;

  localparam logic [3:0] GRACE_LENIENT    = 4'd14;
  localparam logic [3:0] GRACE_AGGRESSIVE = 4'd8;
  localparam logic [3:0] QUIET_LENIENT    = 4'd4;
  localparam logic [3:0] QUIET_AGGRESSIVE = 4'd2;
  localparam logic [5:0] CODE_LEN_VALID   = 6'd5;
  localparam logic [7:0] FIRE_MAX         = 8'd255;
  localparam logic [6:0] LEVEL_MAX        = 7'd100;
  localparam logic [10:0] LEVEL_SCALE     = 11'd100;

  typedef struct packed {
    logic [7:0] code_value;
    logic [5:0] code_length;
    logic [7:0] severity;
  } mae_cfg_t;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] tap_code;
    logic [5:0] tap_length;
    logic       usb;
    logic       link;
  } mae_event_t;

  typedef struct packed {
    logic       enabled;
    logic       active;
    logic       snoozed;
    logic [3:0] span;
    logic [7:0] fire;
    logic [2:0] retries;
    logic [1:0] rise;
    logic [6:0] decay;
    logic [4:0] unsnooze;
  } mae_state_t;

  typedef struct packed {
    mae_state_t st;
    logic       siren;
    logic       warn;
  } mae_work_t;

  typedef struct packed {
    logic       enabled;
    logic       active;
    logic       siren;
    logic       warn;
    logic [3:0] span;
    logic [7:0] fire;
    logic [1:0] result;
    logic [3:0] grace;
  } mae_stat_t;

endpackage

// File: src/mae_core.sv
// Alarm state and event update for the movement alarm block.
// Applies one event per start pulse; depends on mae_pkg.
module mae_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mae_pkg::mae_event_t ev_i,
  input  mae_pkg::mae_cfg_t cfg_i,
  output mae_pkg::mae_stat_t stat_o
);
  import mae_pkg::*;

  mae_state_t st_q, st_d;
  logic       siren_q, siren_d, warn_q, warn_d;
  logic [1:0] res_q, res_d;
  logic [3:0] grace, quiet;

  assign grace = (cfg_i.severity == 8'd0) ? GRACE_LENIENT : GRACE_AGGRESSIVE;
  assign quiet = (cfg_i.severity == 8'd0) ? QUIET_LENIENT : QUIET_AGGRESSIVE;

  function automatic mae_work_t siren_on(mae_work_t w);
    mae_work_t r;
    r = w;
    if (!r.st.active) begin
      r.st.active = 1'b1;
      if (r.st.fire != FIRE_MAX) r.st.fire = r.st.fire + 8'd1;
    end
    r.siren = 1'b1;
    return r;
  endfunction

  function automatic mae_work_t rise_step(mae_work_t w, logic [3:0] g, logic [3:0] qt);
    mae_work_t r;
    r = w;
    if (r.st.span < g) begin
      r.st.active = 1'b0;
      r.st.span   = r.st.span + 4'd1;
      if (r.st.span > qt) r.warn = 1'b1;
      if (r.st.enabled) r.st.rise = TICKS_RISE;
    end else begin
      r = siren_on(r);
    end
    return r;
  endfunction

  always_comb begin
    mae_work_t w;
    logic      fr, fd, fu;
    w       = '0;
    w.st    = st_q;
    fr      = 1'b0;
    fd      = 1'b0;
    fu      = 1'b0;
    res_d   = CR_NONE;
    unique case (mae_op_e'(ev_i.op))
      OP_TICK: begin
        if (w.st.rise != 2'd0) begin
          w.st.rise = w.st.rise - 2'd1;
          fr = (w.st.rise == 2'd0);
        end
        if (w.st.decay != 7'd0) begin
          w.st.decay = w.st.decay - 7'd1;
          fd = (w.st.decay == 7'd0);
        end
        if (w.st.unsnooze != 5'd0) begin
          w.st.unsnooze = w.st.unsnooze - 5'd1;
          fu = (w.st.unsnooze == 5'd0);
        end
        if (fr) w = rise_step(w, grace, quiet);
        if (fd && w.st.span != 4'd0) begin
          w.st.span  = w.st.span - 4'd1;
          w.st.decay = TICKS_DECAY;
        end
        if (fu) begin
          w.st.snoozed = 1'b0;
          w.st.retries = MAX_RETRIES;
        end
      end
      OP_MOVE_ON: begin
        if (w.st.enabled) begin
          if (w.st.rise == 2'd0) w = rise_step(w, grace, quiet);
          w.st.decay = 7'd0;
        end
      end
      OP_MOVE_OFF: begin
        if (w.st.enabled) begin
          if (w.st.decay == 7'd0) w.st.decay = w.st.active ? TICKS_DECAY_ACTIVE : TICKS_DECAY;
          w.st.rise = 2'd0;
        end
      end
      OP_ARM: begin
        w.st.enabled = 1'b1;
        w.st.span    = 4'd0;
        w.st.fire    = 8'd0;
        w.st.retries = MAX_RETRIES;
        w.st.snoozed = 1'b0;
      end
      OP_DISARM: begin
        w.st.enabled = 1'b0;
        w.st.rise    = 2'd0;
        w.st.decay   = 7'd0;
      end
      OP_CODE: begin
        if (ev_i.tap_length == CODE_LEN_VALID && !(!w.st.enabled && ev_i.usb) &&
            cfg_i.code_length >= CODE_LEN_VALID) begin
          if (cfg_i.code_length == CODE_LEN_VALID && cfg_i.code_value == ev_i.tap_code &&
              !w.st.snoozed) begin
            if (w.st.enabled) begin
              w.st.enabled = 1'b0;
              w.st.rise    = 2'd0;
              w.st.decay   = 7'd0;
            end else if (!ev_i.link) begin
              w.st.enabled = 1'b1;
              w.st.span    = 4'd0;
              w.st.fire    = 8'd0;
              w.st.retries = MAX_RETRIES;
              w.st.snoozed = 1'b0;
            end
            res_d = CR_MATCH;
          end else if (w.st.enabled) begin
            if (w.st.retries == 3'd0) begin
              w.st.span    = grace;
              w            = siren_on(w);
              w.st.snoozed = 1'b1;
            end else begin
              w.st.retries = w.st.retries - 3'd1;
            end
            w.st.unsnooze = TICKS_UNSNOOZE;
            res_d = CR_WRONG;
          end
        end
      end
      default: ;
    endcase
    st_d    = w.st;
    siren_d = w.siren;
    warn_d  = w.warn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= '0;
      siren_q <= 1'b0;
      warn_q  <= 1'b0;
      res_q   <= CR_NONE;
    end else if (start_i) begin
      st_q    <= st_d;
      siren_q <= siren_d;
      warn_q  <= warn_d;
      res_q   <= res_d;
    end
  end

  assign stat_o.enabled = st_q.enabled;
  assign stat_o.active  = st_q.active;
  assign stat_o.siren   = siren_q;
  assign stat_o.warn    = warn_q;
  assign stat_o.span    = st_q.span;
  assign stat_o.fire    = st_q.fire;
  assign stat_o.result  = res_q;
  assign stat_o.grace   = grace;

endmodule

// File: src/mae_div.sv
// Shift-subtract divider for the warning level, one quotient bit per cycle.
// Standalone; no package dependency.
module mae_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [10:0] num_i,
  input  logic [3:0]  den_i,
  output logic        done_o,
  output logic [7:0]  quot_o
);

  logic        busy_q, busy_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [10:0] rem_q, rem_d;
  logic [7:0]  quot_q, quot_d;
  logic [3:0]  den_q, den_d;
  logic [10:0] den_sh;

  assign den_sh = 11'(den_q) << cnt_q;
  assign done_o = busy_q && (cnt_q == 3'd0);
  assign quot_o = quot_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 3'd7;
      rem_d  = num_i;
      quot_d = 8'd0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (rem_q >= den_sh) begin
        rem_d         = rem_q - den_sh;
        quot_d[cnt_q] = 1'b1;
      end
      if (cnt_q == 3'd0) busy_d = 1'b0;
      else cnt_d = cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    den_q  <= den_d;
  end

endmodule

// File: src/movement_alarm_escalation_top.sv
// Top level of the movement alarm escalation block: stream ports, config
// registers, sequencer and output register. Uses mae_pkg, mae_core, mae_div.
//
// One event word is taken when the block is idle and answered by exactly one
// result word. From acceptance to the result register an event passes
// through the sequencer states in order: apply the event, load the divider,
// run the shift-subtract divider that forms the warning level, and move the
// result out, which waits while an earlier result is still unaccepted. The
// next event word is taken only back in idle, after the result is loaded. Input
// is taken again while a finished result still waits on the master side.
module movement_alarm_escalation_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[2:0], tap_code[10:3], tap_length[16:11], usb_plugged[17],
  // link_connected[18], zero fill[23:19]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // armed[0], siren_start[1], triggered[2], warn_start[3], warn_level[10:4],
  // escalation[14:11], code_result[16:15], trigger_count[24:17], zero[31:25]
  output logic [31:0] m_axis_tdata
);
  import mae_pkg::*;

  mae_seq_e   seq_q, seq_d;
  mae_cfg_t   cfg_q;
  mae_event_t ev_q;
  mae_stat_t  stat;
  logic       s_acc, core_start, div_start, out_load;
  logic       div_done;
  logic [7:0] quot;
  logic [6:0] level;
  logic       m_valid_q, m_valid_d;
  logic [31:0] m_data_q;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_CODE_VALUE:  cfg_q.code_value  <= cfg_wdata_i;
        CFG_CODE_LENGTH: cfg_q.code_length <= cfg_wdata_i[5:0];
        CFG_SEVERITY:    cfg_q.severity    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      ev_q.op         <= s_axis_tdata[2:0];
      ev_q.tap_code   <= s_axis_tdata[10:3];
      ev_q.tap_length <= s_axis_tdata[16:11];
      ev_q.usb        <= s_axis_tdata[17];
      ev_q.link       <= s_axis_tdata[18];
    end
  end

  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE: if (s_acc) seq_d = SEQ_EXEC;
      SEQ_EXEC: seq_d = SEQ_LOAD;
      SEQ_LOAD: seq_d = SEQ_DIV;
      SEQ_DIV:  if (div_done) seq_d = SEQ_OUT;
      SEQ_OUT:  if (out_load) seq_d = SEQ_IDLE;
      default:  seq_d = SEQ_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (seq_q == SEQ_IDLE);
    core_start    = (seq_q == SEQ_EXEC);
    div_start     = (seq_q == SEQ_LOAD);
    out_load      = (seq_q == SEQ_OUT) && (!m_valid_q || m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seq_q <= SEQ_IDLE;
    else         seq_q <= seq_d;
  end

  mae_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (core_start),
    .ev_i    (ev_q),
    .cfg_i   (cfg_q),
    .stat_o  (stat)
  );

  mae_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (11'(stat.span) * LEVEL_SCALE),
    .den_i   (stat.grace),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign level = (quot > 8'(LEVEL_MAX)) ? LEVEL_MAX : quot[6:0];

  always_comb begin
    priority if (out_load) m_valid_d = 1'b1;
    else if (m_axis_tready) m_valid_d = 1'b0;
    else m_valid_d = m_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else         m_valid_q <= m_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {7'd0, stat.fire, stat.result, stat.span, level,
                   stat.warn, stat.active, stat.siren, stat.enabled};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// File: src/mae_checker.sv
// Port-level checks for the movement alarm escalation top level.
// Bound to movement_alarm_escalation_top; no package dependency.
module mae_port_checks (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again right after an accepted word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result word changed or dropped");

  a_fields_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10:4] <= 7'd100 && m_axis_tdata[16:15] != 2'd3 &&
                       m_axis_tdata[14:11] != 4'd15))
    else $error("result field out of range");

  a_siren_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[2])
    else $error("siren started without alarm active");

endmodule

bind movement_alarm_escalation_top mae_port_checks u_mae_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
